// ===== sv/wfnm_pkg.sv =====
// Shared types, codes and constants for the weighted feature nearest-match unit.
// No dependencies; used by every module of the block.
`default_nettype none

package wfnm_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int MAX_CLIPS_DEF   = 64;
    localparam int VALUE_BITS_DEF  = 24;

    localparam int ITEM_VALUE_W = 32;
    localparam int QDEPTH       = 2;

    localparam int NFEAT        = 13;
    localparam int NQUERY       = 9;
    localparam int SLOT_VEL     = 6;
    localparam int SLOT_TRAJ    = 9;
    localparam int SLOT_VX      = 6;
    localparam int SLOT_VZ      = 8;
    localparam int SLOT_LAST    = 12;

    localparam logic [16:0] C03 = 17'd19661;
    localparam logic [16:0] C06 = 17'd39322;
    localparam int ROUND_HALF   = 32768;

    localparam logic [62:0] COST_SAT = {63{1'b1}};

    localparam int CFG_W    = 24;
    localparam int CFG_AW   = 3;
    localparam logic [CFG_AW-1:0] CFG_POSE  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_VEL   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TRAJ  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_KEEP  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_COUNT = 3'd4;

    localparam logic [15:0] POSE_W_RST = 16'd256;
    localparam logic [15:0] VEL_W_RST  = 16'd256;
    localparam logic [15:0] TRAJ_W_RST = 16'd256;
    localparam logic [23:0] KEEP_RST   = 24'd13107;
    localparam logic [10:0] COUNT_RST  = 11'd0;

    localparam int OUT_BITS = 105;
    localparam int OUT_W    = 112;

    typedef enum logic [1:0] {
        KIND_FEAT   = 2'd0,
        KIND_CLIP   = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DRAIN,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DEC,
        S_OUT
    } state_t;

    typedef struct packed {
        kind_t                           kind;
        logic [9:0]                      idx;
        logic [3:0]                      slot;
        logic signed [ITEM_VALUE_W-1:0]  value;
        logic [5:0]                      clip;
        logic [23:0]                     stime;
        logic [23:0]                     dur;
        logic [23:0]                     now;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

`default_nettype wire

// ===== sv/wfnm_front.sv =====
// Front end: accepts stream items, drops writes that fall out of range,
// and queues the rest for the back end. Depends on wfnm_pkg.
`default_nettype none

module wfnm_front #(
    parameter int MAX_ENTRIES = wfnm_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_CLIPS   = wfnm_pkg::MAX_CLIPS_DEF,
    parameter int VALUE_BITS  = wfnm_pkg::VALUE_BITS_DEF,
    parameter int IN_W        = 120
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [IN_W-1:0]     s_tdata,
    input  wire logic [1:0]          s_tuser,
    output wfnm_pkg::queue_head_t    head,
    input  wire logic                pop
);

    localparam int CNT_W = $clog2(wfnm_pkg::QDEPTH + 1);
    localparam int V_LO  = 14;
    localparam int C_LO  = V_LO + VALUE_BITS;

    wfnm_pkg::item_t             item;
    wfnm_pkg::item_t             q_reg [wfnm_pkg::QDEPTH];
    logic                        wr_ptr_reg, wr_ptr_next;
    logic                        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        useful;
    logic                        push;

    always_comb
    begin
        item.kind  = wfnm_pkg::kind_t'(s_tuser);
        item.idx   = s_tdata[9:0];
        item.slot  = s_tdata[13:10];
        item.value = wfnm_pkg::ITEM_VALUE_W'(signed'(s_tdata[C_LO-1:V_LO]));
        item.clip  = s_tdata[C_LO+5:C_LO];
        item.stime = s_tdata[C_LO+29:C_LO+6];
        item.dur   = s_tdata[C_LO+53:C_LO+30];
        item.now   = s_tdata[C_LO+77:C_LO+54];
    end

    always_comb
    begin
        case (item.kind)
            wfnm_pkg::KIND_FEAT:
                useful = (32'(item.slot) < wfnm_pkg::NFEAT) && (32'(item.idx) < MAX_ENTRIES);
            wfnm_pkg::KIND_CLIP:
                useful = (32'(item.idx) < MAX_ENTRIES) && (32'(item.clip) < MAX_CLIPS);
            wfnm_pkg::KIND_QUERY:
                useful = 32'(item.slot) < wfnm_pkg::NQUERY;
            default:
                useful = 1'b1;
        endcase
    end

    assign s_tready = count_reg != CNT_W'(wfnm_pkg::QDEPTH);
    assign push     = s_tvalid && s_tready && useful;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    assign head.valid = count_reg != '0;
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== sv/wfnm_back.sv =====
// Back end: configuration registers, table memories, the cost pipeline that
// walks the table, and the keep-or-restart decision. Depends on wfnm_pkg.
`default_nettype none

module wfnm_back #(
    parameter int MAX_ENTRIES = wfnm_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_CLIPS   = wfnm_pkg::MAX_CLIPS_DEF,
    parameter int VALUE_BITS  = wfnm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [wfnm_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [wfnm_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire wfnm_pkg::queue_head_t         head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [wfnm_pkg::OUT_W-1:0]         m_tdata
);

    localparam int EA_W   = $clog2(MAX_ENTRIES);
    localparam int EC_W   = $clog2(MAX_ENTRIES + 1);
    localparam int FDEPTH = MAX_ENTRIES * wfnm_pkg::NFEAT;
    localparam int FA_W   = $clog2(FDEPTH);
    localparam int CL_W   = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
    localparam int VB     = VALUE_BITS;
    localparam int TW     = VB + 1;
    localparam int MW     = VB + 2;
    localparam int SQ_W   = 2 * MW;
    localparam int PW     = (SQ_W + 16 > 64) ? SQ_W + 16 : 64;
    localparam int PAD_W  = wfnm_pkg::OUT_W - wfnm_pkg::OUT_BITS;

    wfnm_pkg::state_t  state_reg, state_next;
    wfnm_pkg::item_t   it;

    logic [15:0]       pose_w_reg, vel_w_reg, traj_w_reg;
    logic [23:0]       keep_reg;
    logic [10:0]       cnt_cfg_reg;

    logic signed [VB-1:0] query_reg [wfnm_pkg::NQUERY];
    logic signed [TW-1:0] tgt_reg [4];

    logic signed [VB-1:0] feat_mem [FDEPTH];
    logic [5:0]           clip_mem [MAX_ENTRIES];
    logic [23:0]          time_mem [MAX_ENTRIES];
    logic [23:0]          dur_mem  [MAX_CLIPS];

    logic signed [VB-1:0] feat_rd_reg;
    logic [5:0]           clip_rd_reg;
    logic [23:0]          time_rd_reg;
    logic [23:0]          dur_rd_reg;
    logic [EA_W-1:0]      clip_raddr;

    logic [FA_W-1:0]      waddr;
    logic [FA_W-1:0]      faddr_reg;
    logic [EA_W-1:0]      e_reg;
    logic [3:0]           k_reg;
    logic [EC_W-1:0]      count_reg, count_eff;
    logic                 empty_reg;
    logic                 last_issue;

    logic                 issue, load_out, out_free;

    logic                 p1_v, p2_v, p3_v, p4_v, p5_done;
    logic [3:0]           p1_k, p2_k, p3_k, p4_k;
    logic [EA_W-1:0]      p1_e, p2_e, p3_e, p4_e, p5_e;
    logic [MW-1:0]        mag_reg;
    logic [15:0]          w2_reg, w3_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [62:0]          term_reg, acc_reg, acc_next;
    logic [EA_W-1:0]      best_reg;
    logic [62:0]          bestc_reg;

    logic signed [TW-1:0] opnd;
    logic [15:0]          wsel;
    logic signed [MW-1:0] diff;
    logic [PW-1:0]        prod;

    logic [5:0]           bclip_reg;
    logic [23:0]          btime_reg, now_reg, dur_reg, gap_reg;
    logic                 match_reg, keep_dec_reg;
    logic [23:0]          gap_abs;
    logic signed [25:0]   dg, g2;

    logic                 cur_v_reg;
    logic [EA_W-1:0]      cur_idx_reg;
    logic                 out_v_reg;
    logic [wfnm_pkg::OUT_BITS-1:0] out_data_reg;

    function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? wfnm_pkg::COST_SAT : s[62:0];
    endfunction

    function automatic logic signed [TW-1:0] scale(input logic signed [VB-1:0] v,
                                                   input logic [16:0] c);
        logic signed [VB+17:0] p;
        p = (VB+18)'(v) * (VB+18)'(signed'({1'b0, c})) + (VB+18)'(wfnm_pkg::ROUND_HALF);
        return p[VB+16:16];
    endfunction

    assign it        = head.item;
    assign out_free  = !out_v_reg || m_tready;
    assign count_eff = (32'(cnt_cfg_reg) > MAX_ENTRIES) ? EC_W'(MAX_ENTRIES)
                                                        : EC_W'(cnt_cfg_reg);
    assign last_issue = (e_reg == EA_W'(count_reg - 1'b1)) &&
                        (k_reg == 4'(wfnm_pkg::SLOT_LAST));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wfnm_pkg::S_IDLE:
                if (head.valid && it.kind == wfnm_pkg::KIND_SEARCH)
                    state_next = (count_eff == '0) ? wfnm_pkg::S_OUT : wfnm_pkg::S_SETUP;
            wfnm_pkg::S_SETUP: state_next = wfnm_pkg::S_WALK;
            wfnm_pkg::S_WALK:
                if (last_issue)
                    state_next = wfnm_pkg::S_DRAIN;
            wfnm_pkg::S_DRAIN:
                if (!(p1_v || p2_v || p3_v || p4_v || p5_done))
                    state_next = wfnm_pkg::S_RD1;
            wfnm_pkg::S_RD1: state_next = wfnm_pkg::S_RD2;
            wfnm_pkg::S_RD2: state_next = wfnm_pkg::S_RD3;
            wfnm_pkg::S_RD3: state_next = wfnm_pkg::S_DEC;
            wfnm_pkg::S_DEC: state_next = wfnm_pkg::S_OUT;
            wfnm_pkg::S_OUT:
                if (out_free)
                    state_next = wfnm_pkg::S_IDLE;
            default: state_next = wfnm_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop        = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        clip_raddr = best_reg;
        case (state_reg)
            wfnm_pkg::S_IDLE: pop = head.valid;
            wfnm_pkg::S_WALK: issue = 1'b1;
            wfnm_pkg::S_RD2:  clip_raddr = cur_idx_reg;
            wfnm_pkg::S_OUT:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wfnm_pkg::S_IDLE;
            pose_w_reg  <= wfnm_pkg::POSE_W_RST;
            vel_w_reg   <= wfnm_pkg::VEL_W_RST;
            traj_w_reg  <= wfnm_pkg::TRAJ_W_RST;
            keep_reg    <= wfnm_pkg::KEEP_RST;
            cnt_cfg_reg <= wfnm_pkg::COUNT_RST;
            for (int i = 0; i < wfnm_pkg::NQUERY; i++)
                query_reg[i] <= '0;
            cur_v_reg   <= 1'b0;
            cur_idx_reg <= '0;
            out_v_reg   <= 1'b0;
            p1_v        <= 1'b0;
            p2_v        <= 1'b0;
            p3_v        <= 1'b0;
            p4_v        <= 1'b0;
            p5_done     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                case (cfg_addr)
                    wfnm_pkg::CFG_POSE:  pose_w_reg  <= cfg_wdata[15:0];
                    wfnm_pkg::CFG_VEL:   vel_w_reg   <= cfg_wdata[15:0];
                    wfnm_pkg::CFG_TRAJ:  traj_w_reg  <= cfg_wdata[15:0];
                    wfnm_pkg::CFG_KEEP:  keep_reg    <= cfg_wdata[23:0];
                    wfnm_pkg::CFG_COUNT: cnt_cfg_reg <= cfg_wdata[10:0];
                    default: ;
                endcase
            end
            if (pop && it.kind == wfnm_pkg::KIND_QUERY)
                query_reg[it.slot] <= it.value[VB-1:0];
            p1_v    <= issue;
            p2_v    <= p1_v;
            p3_v    <= p2_v;
            p4_v    <= p3_v;
            p5_done <= p4_v && (p4_k == 4'(wfnm_pkg::SLOT_LAST));
            if (load_out)
            begin
                out_v_reg <= 1'b1;
                if (!empty_reg)
                begin
                    cur_v_reg   <= 1'b1;
                    cur_idx_reg <= best_reg;
                end
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // table writes and registered reads
    assign waddr = (FA_W'(it.idx) << 3) + (FA_W'(it.idx) << 2) + FA_W'(it.idx)
                 + FA_W'(it.slot);

    always_ff @(posedge clk)
    begin
        if (pop && it.kind == wfnm_pkg::KIND_FEAT)
            feat_mem[waddr] <= it.value[VB-1:0];
        if (pop && it.kind == wfnm_pkg::KIND_CLIP)
        begin
            clip_mem[EA_W'(it.idx)] <= it.clip;
            time_mem[EA_W'(it.idx)] <= it.stime;
            dur_mem[CL_W'(it.clip)] <= it.dur;
        end
        feat_rd_reg <= feat_mem[faddr_reg];
        clip_rd_reg <= clip_mem[clip_raddr];
        time_rd_reg <= time_mem[best_reg];
        dur_rd_reg  <= dur_mem[CL_W'(clip_rd_reg)];
    end

    // search sequencing
    always_ff @(posedge clk)
    begin
        if (pop && it.kind == wfnm_pkg::KIND_SEARCH)
        begin
            count_reg <= count_eff;
            empty_reg <= count_eff == '0;
            now_reg   <= it.now;
        end
        if (state_reg == wfnm_pkg::S_SETUP)
        begin
            tgt_reg[0] <= scale(query_reg[wfnm_pkg::SLOT_VX], wfnm_pkg::C03);
            tgt_reg[1] <= scale(query_reg[wfnm_pkg::SLOT_VZ], wfnm_pkg::C03);
            tgt_reg[2] <= scale(query_reg[wfnm_pkg::SLOT_VX], wfnm_pkg::C06);
            tgt_reg[3] <= scale(query_reg[wfnm_pkg::SLOT_VZ], wfnm_pkg::C06);
            faddr_reg  <= '0;
            e_reg      <= '0;
            k_reg      <= '0;
        end
        else if (issue)
        begin
            faddr_reg <= faddr_reg + 1'b1;
            if (k_reg == 4'(wfnm_pkg::SLOT_LAST))
            begin
                k_reg <= '0;
                e_reg <= e_reg + 1'b1;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
        p1_k <= k_reg;
        p1_e <= e_reg;
    end

    // cost pipeline
    always_comb
    begin
        if (32'(p1_k) < wfnm_pkg::SLOT_VEL)
        begin
            opnd = TW'(query_reg[p1_k]);
            wsel = pose_w_reg;
        end
        else if (32'(p1_k) < wfnm_pkg::SLOT_TRAJ)
        begin
            opnd = TW'(query_reg[p1_k]);
            wsel = vel_w_reg;
        end
        else
        begin
            opnd = tgt_reg[2'(p1_k - 4'(wfnm_pkg::SLOT_TRAJ))];
            wsel = traj_w_reg;
        end
        diff = MW'(feat_rd_reg) - MW'(opnd);
        prod = PW'(sq_reg) * PW'(w3_reg);
        acc_next = (p4_k == '0) ? term_reg : sat_add(acc_reg, term_reg);
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= diff[MW-1] ? MW'(-diff) : MW'(diff);
        w2_reg   <= wsel;
        p2_k     <= p1_k;
        p2_e     <= p1_e;
        sq_reg   <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        w3_reg   <= w2_reg;
        p3_k     <= p2_k;
        p3_e     <= p2_e;
        term_reg <= (prod > PW'(wfnm_pkg::COST_SAT)) ? wfnm_pkg::COST_SAT : prod[62:0];
        p4_k     <= p3_k;
        p4_e     <= p3_e;
        if (p4_v)
        begin
            acc_reg <= acc_next;
            p5_e    <= p4_e;
        end
        if (p5_done && (p5_e == '0 || acc_reg < bestc_reg))
        begin
            bestc_reg <= acc_reg;
            best_reg  <= p5_e;
        end
    end

    // keep-or-restart decision
    assign gap_abs = (now_reg >= time_rd_reg) ? now_reg - time_rd_reg
                                              : time_rd_reg - now_reg;
    assign dg = signed'({2'b00, dur_reg}) - signed'({2'b00, gap_reg});
    assign g2 = (dur_reg != '0 && dg < signed'({2'b00, gap_reg})) ? dg
                                                                 : signed'({2'b00, gap_reg});

    always_ff @(posedge clk)
    begin
        case (state_reg)
            wfnm_pkg::S_RD2:
            begin
                bclip_reg <= clip_rd_reg;
                gap_reg   <= gap_abs;
                btime_reg <= time_rd_reg;
            end
            wfnm_pkg::S_RD3:
            begin
                dur_reg   <= dur_rd_reg;
                match_reg <= cur_v_reg && (EC_W'(cur_idx_reg) < count_reg) &&
                             (clip_rd_reg == bclip_reg);
            end
            wfnm_pkg::S_DEC:
                keep_dec_reg <= match_reg && (g2 <= signed'({2'b00, keep_reg}));
            default: ;
        endcase
        if (load_out)
        begin
            if (empty_reg)
                out_data_reg <= '0;
            else
                out_data_reg <= {bestc_reg, !keep_dec_reg, btime_reg, bclip_reg,
                                 10'(best_reg), 1'b1};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {PAD_W'(0), out_data_reg};

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == wfnm_pkg::S_IDLE)
        else $error("queue popped outside idle");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wfnm_pkg::S_RD1 |-> !(p1_v || p2_v || p3_v || p4_v || p5_done))
        else $error("cost pipeline busy at decision");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_data_reg[0] |-> out_data_reg == '0)
        else $error("empty search carries nonzero fields");

    a_cur_set: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && !empty_reg |=> cur_v_reg && out_v_reg)
        else $error("current entry not recorded");

endmodule

`default_nettype wire

// ===== sv/weighted_feature_nearest_match_unit.sv =====
// Top level of the weighted feature nearest-match unit: front queue and back
// search engine. Depends on wfnm_pkg, wfnm_front and wfnm_back.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata, s_tuser (request kind)
//  m_*     | out | m_tvalid/m_tready  | m_tdata (search result)
//  cfg_*   | in  | cfg_wen            | cfg_addr, cfg_wdata
//
// The back end pops loads back to back while idle; the front queue takes one
// transfer per cycle while it has room. During a search the feature memory
// delivers one feature per cycle into the cost pipeline. An empty search
// skips the walk and goes straight to the output state.
// Reset clears control, configuration and query registers; table memories
// hold garbage until loaded. A stalled result holds in the output register.
`default_nettype none

module weighted_feature_nearest_match_unit #(
    parameter int MAX_ENTRIES = wfnm_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_CLIPS   = wfnm_pkg::MAX_CLIPS_DEF,
    parameter int VALUE_BITS  = wfnm_pkg::VALUE_BITS_DEF,
    parameter int IN_W        = ((92 + VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // entry_index, slot, value, clip_id, sample_time, clip_duration, clip_time_now
    input  wire logic [IN_W-1:0]               s_tdata,
    // req_type
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // found, best_index, best_clip, start_time, restart, best_cost
    output logic [wfnm_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                          cfg_wen,
    input  wire logic [wfnm_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [wfnm_pkg::CFG_W-1:0]    cfg_wdata
);

    wfnm_pkg::queue_head_t head;
    logic                  pop;

    wfnm_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_CLIPS   (MAX_CLIPS),
        .VALUE_BITS  (VALUE_BITS),
        .IN_W        (IN_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    wfnm_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_CLIPS   (MAX_CLIPS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
